[design/cdq_pkg.sv]
package cdq_pkg;

  localparam int unsigned Depth = 8;
  localparam int unsigned NumCells = Depth - 1;
  localparam int unsigned WordW = 32;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_FRONT = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    op_e                     opcode;
    logic signed [WordW-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [WordW-1:0] popped_value;
    status_e                 status;
    logic                    now_empty;
  } out_t;

  typedef struct packed {
    logic en;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic                    occ;
    logic signed [WordW-1:0] data;
  } link_t;

  localparam logic signed [WordW-1:0] NoWord = '1;

endpackage

[design/cdq_cell.sv]
module cdq_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cdq_pkg::cmd_t                        cmd_i,
  input  logic signed [cdq_pkg::WordW-1:0]     push_value_i,
  input  cdq_pkg::link_t                       left_i,
  input  cdq_pkg::link_t                       right_i,
  output cdq_pkg::link_t                       cell_o,
  output logic                                 last_o,
  output logic                                 occ_next_o
);

  logic                                occ_q, occ_d;
  logic signed [cdq_pkg::WordW-1:0]    data_q, data_d;

  always_comb begin
    occ_d  = occ_q;
    data_d = data_q;
    if (cmd_i.en) begin
      unique case (cmd_i.op)
        cdq_pkg::OP_PUSH_FRONT: begin
          occ_d  = left_i.occ;
          data_d = left_i.data;
        end
        cdq_pkg::OP_POP_FRONT: begin
          occ_d  = right_i.occ;
          data_d = right_i.data;
        end
        cdq_pkg::OP_PUSH_BACK: begin
          if (!occ_q && left_i.occ) begin
            occ_d  = 1'b1;
            data_d = push_value_i;
          end
        end
        cdq_pkg::OP_POP_BACK: begin
          if (occ_q && !right_i.occ) begin
            occ_d = 1'b0;
          end
        end
        default: begin
          occ_d = occ_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign cell_o.occ  = occ_q;
  assign cell_o.data = data_q;
  assign last_o      = occ_q & ~right_i.occ;
  assign occ_next_o  = occ_d;

endmodule

[design/circular_deque_core.sv]
// channel   direction  handshake              payload
// in        request    in_valid_i/in_stall_o    cdq_pkg::in_t
// out       result     out_valid_o/out_stall_i  cdq_pkg::out_t
//
// one request is taken per cycle unless in_stall_o is high; its result appears in
// the output register on the next cycle, set by one shift step along the row of cells
// reset empties every cell (occupancy flags only); stored words are not cleared
// a stalled result holds the output register and stalls the input side
module circular_deque_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cdq_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cdq_pkg::out_t  out_o
);

  localparam int unsigned N = cdq_pkg::NumCells;

  cdq_pkg::link_t                     cells [N];
  cdq_pkg::link_t                     lefts [N];
  cdq_pkg::link_t                     rights [N];
  logic [N-1:0]                       last;
  logic [N-1:0]                       occ_next;
  cdq_pkg::cmd_t                      cmd;
  logic                               accept, is_push, full, empty, refused;
  logic signed [cdq_pkg::WordW-1:0]   tail_data;
  cdq_pkg::out_t                      res_d, out_q;
  logic                               out_valid_q, out_valid_d;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i].occ  = 1'b1;
      assign lefts[i].data = in_i.push_value;
    end else begin : g_mid
      assign lefts[i] = cells[i-1];
    end
    if (i == N - 1) begin : g_end
      assign rights[i].occ  = 1'b0;
      assign rights[i].data = '0;
    end else begin : g_inner
      assign rights[i] = cells[i+1];
    end

    cdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .push_value_i (in_i.push_value),
      .left_i       (lefts[i]),
      .right_i      (rights[i]),
      .cell_o       (cells[i]),
      .last_o       (last[i]),
      .occ_next_o   (occ_next[i])
    );
  end

  always_comb begin
    tail_data = '0;
    for (int i = 0; i < N; i++) begin
      tail_data = tail_data | (cells[i].data & {cdq_pkg::WordW{last[i]}});
    end
  end

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign empty      = ~cells[0].occ;
  assign full       = cells[N-1].occ;
  assign is_push    = (in_i.opcode == cdq_pkg::OP_PUSH_BACK) ||
                      (in_i.opcode == cdq_pkg::OP_PUSH_FRONT);
  assign refused    = is_push ? full : empty;
  assign cmd.en     = accept & ~refused;
  assign cmd.op     = in_i.opcode;

  always_comb begin
    res_d.popped_value = cdq_pkg::NoWord;
    res_d.status       = cdq_pkg::ST_OK;
    if (refused) begin
      res_d.status = is_push ? cdq_pkg::ST_OVERFLOW : cdq_pkg::ST_UNDERFLOW;
    end else if (in_i.opcode == cdq_pkg::OP_POP_FRONT) begin
      res_d.popped_value = cells[0].data;
    end else if (in_i.opcode == cdq_pkg::OP_POP_BACK) begin
      res_d.popped_value = tail_data;
    end
    res_d.now_empty = refused ? empty : ~occ_next[0];
  end

  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
